// ===== design/ecbs_pkg.sv =====
// Package for the endpoint circuit breaker selector: sizes, opcodes, status codes.
// No dependencies.
package ecbs_pkg;
    localparam int TABLE_ENTRIES = 64;
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_REMOVE  = 3'd1;
    localparam logic [2:0] OP_SELECT  = 3'd2;
    localparam logic [2:0] OP_SUCCESS = 3'd3;
    localparam logic [2:0] OP_FAILURE = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    localparam int CFG_TRY_SECOND = 0;
    localparam int CFG_RECOVERY   = 1;

    // One table entry as it is stored in the entry memory.
    typedef struct packed {
        logic [47:0] key;
        logic [15:0] limit;
        logic [15:0] fails;
        logic        tripped;
        logic [31:0] reopen;
    } t_entry;

    // Handshake between the top level and the modulo unit.
    typedef struct packed {
        logic          start;
        logic [30:0]   dividend;
        logic [CW-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic          done;
        logic [IW-1:0] rem;
    } t_mod_rsp;
endpackage

// ===== design/ecbs_mod.sv =====
// Restoring modulo unit: 31-bit dividend by a table-sized divisor, one bit a cycle.
// Depends on ecbs_pkg.
module ecbs_mod import ecbs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mod_req i_req,
    output t_mod_rsp o_rsp
);
    logic [30:0]   r_quo;
    logic [CW:0]   r_rem;
    logic [CW-1:0] r_div;
    logic [4:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [CW:0]   n_shift;

    assign n_shift = {r_rem[CW-1:0], r_quo[30]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_quo  <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_quo <= {r_quo[29:0], 1'b0};
                if (n_shift >= {1'b0, r_div}) begin
                    r_rem <= n_shift - {1'b0, r_div};
                end else begin
                    r_rem <= n_shift;
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd30) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[IW-1:0];
endmodule

// ===== design/endpoint_circuit_breaker_selector_core.sv =====
// Endpoint circuit breaker selector, top level: sequencer and entry memory.
// Depends on ecbs_pkg and ecbs_mod.
//
// One item at a time. Add writes the entry at acceptance. Reports read,
// modify and write back the entry, then give the result. Remove walks the
// table through the entry memory, one read per entry and one compacting
// write per kept entry. Select sweeps the table once for recovery, then
// runs the bit-serial modulo unit and reads the chosen entry; a redraw runs
// a second modulo and read. Select on an empty table, or with none alive
// after recovery, goes straight to the result.
// The result sits in an output register; the next item is taken once it is
// handed off. No clearing pass: entry count and alive count live in
// flip-flops, and every entry read was written by an add first.
module endpoint_circuit_breaker_selector_core import ecbs_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [2:0]    i_opcode,
    input  logic [31:0]   i_now_seconds,
    input  logic [47:0]   i_endpoint_key,
    input  logic [15:0]   i_fail_limit,
    input  logic [5:0]    i_entry_position,
    input  logic [30:0]   i_random_first,
    input  logic [30:0]   i_random_second,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [0:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [1:0]    o_status,
    output logic [5:0]    o_selected_position,
    output logic [47:0]   o_selected_key,
    output logic [6:0]    o_removed_count,
    output logic [6:0]    o_alive_count,
    output logic [6:0]    o_entry_count
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RMW_RD = 4'd1;
    localparam logic [3:0] S_RMW_WR = 4'd2;
    localparam logic [3:0] S_REM    = 4'd3;
    localparam logic [3:0] S_REC    = 4'd4;
    localparam logic [3:0] S_MOD1   = 4'd5;
    localparam logic [3:0] S_PICK1  = 4'd6;
    localparam logic [3:0] S_MOD2   = 4'd7;
    localparam logic [3:0] S_PICK2  = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;
    localparam logic [3:0] S_RDWAIT = 4'd10;

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rd;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    t_entry        mem_wd;
    logic [IW-1:0] mem_ra;

    logic [3:0]    r_state;
    logic [CW-1:0] r_used, r_alive, r_rm, r_w;
    logic [CW-1:0] r_i;         // read index of a sweep
    logic          r_rdv;       // r_rd holds entry r_i-1 of the sweep
    logic [IW-1:0] r_pos;
    logic [2:0]    r_op;
    logic [31:0]   r_now;
    logic [47:0]   r_key;
    logic [30:0]   r_r1;
    logic [30:0]   r_r2;
    logic          r_try;
    logic [15:0]   r_recov;
    logic          r_ovalid;
    logic [1:0]    r_status;
    logic [IW-1:0] r_spos;
    logic [47:0]   r_skey;
    logic          r_second;

    t_mod_req mreq;
    t_mod_rsp mrsp;

    ecbs_mod u_mod (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mreq), .o_rsp(mrsp));

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    assign o_stall     = (r_state != S_IDLE) || r_ovalid;
    assign o_cfg_ready = 1'b1;
    logic accept;
    assign accept = i_valid && !o_stall;

    // Modify step of a report, and recovery step of a select sweep, from the entry read back.
    t_entry        rmw;
    logic [32:0]   reopen_sum;
    logic          rmw_trip, rmw_clr;
    t_entry        rec;
    logic          rec_hit;
    always_comb begin
        rmw        = r_rd;
        rmw_trip   = 1'b0;
        rmw_clr    = 1'b0;
        reopen_sum = {1'b0, r_now} + {17'd0, r_recov};
        if (r_op == OP_SUCCESS) begin
            rmw.fails   = '0;
            rmw.tripped = 1'b0;
            rmw_clr     = r_rd.tripped;
        end else begin
            if (r_rd.fails != 16'hFFFF) begin
                rmw.fails = r_rd.fails + 16'd1;
            end
            if (!r_rd.tripped && rmw.fails >= r_rd.limit) begin
                rmw.tripped = 1'b1;
                rmw.reopen  = reopen_sum[32] ? 32'hFFFF_FFFF : reopen_sum[31:0];
                rmw_trip    = 1'b1;
            end
        end
        rec     = r_rd;
        rec_hit = r_rd.tripped && (r_now >= r_rd.reopen);
        if (rec_hit) begin
            rec.tripped = 1'b0;
            if (r_rd.fails >= r_rd.limit) begin
                rec.fails = r_rd.limit - 16'd1;
            end
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_pos;
        mem_wd = rmw;
        mem_ra = r_i[IW-1:0];
        mreq.start    = 1'b0;
        mreq.dividend = r_r2;
        mreq.divisor  = r_used;
        if (accept && i_opcode == OP_ADD && r_used != CW'(TABLE_ENTRIES)) begin
            mem_we = 1'b1;
            mem_wa = r_used[IW-1:0];
            mem_wd.key     = i_endpoint_key;
            mem_wd.limit   = (i_fail_limit == 16'd0) ? 16'd1 : i_fail_limit;
            mem_wd.fails   = '0;
            mem_wd.tripped = 1'b0;
            mem_wd.reopen  = '0;
        end
        if (accept) begin
            mem_ra = i_entry_position;
        end
        case (r_state)
            S_RMW_RD: begin
                // Hold the reported entry in r_rd for the write back.
                mem_ra = r_pos;
            end
            S_RMW_WR: begin
                mem_we = 1'b1;
            end
            S_REM: begin
                mem_we = r_rdv && (r_rd.key != r_key);
                mem_wa = r_w[IW-1:0];
                mem_wd = r_rd;
            end
            S_REC: begin
                mem_we = r_rdv && rec_hit;
                mem_wa = IW'(r_i - CW'(1));
                mem_wd = rec;
                // Launch the first draw once the sweep is over and an entry is alive.
                if (!r_rdv && (r_i >= r_used) && (r_alive != '0)) begin
                    mreq.start    = 1'b1;
                    mreq.dividend = r_r1;
                end
            end
            S_MOD1, S_MOD2: begin
                mem_ra = mrsp.rem;
            end
            S_RDWAIT: begin
                mem_ra = r_spos;
            end
            S_PICK1: begin
                mreq.start = r_rd.tripped && r_try;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_alive  <= '0;
            r_ovalid <= 1'b0;
            r_try    <= 1'b1;
            r_recov  <= 16'd30;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == 1'(CFG_TRY_SECOND)) begin
                    r_try <= i_cfg_data[0];
                end else begin
                    r_recov <= i_cfg_data;
                end
            end
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op     <= i_opcode;
                        r_now    <= i_now_seconds;
                        r_key    <= i_endpoint_key;
                        r_r1     <= i_random_first;
                        r_r2     <= i_random_second;
                        r_pos    <= i_entry_position;
                        r_rm     <= '0;
                        r_spos   <= '0;
                        r_skey   <= '0;
                        r_status <= ST_NONE;
                        r_second <= 1'b0;
                        r_i      <= '0;
                        r_w      <= '0;
                        r_rdv    <= 1'b0;
                        case (i_opcode)
                            OP_ADD: begin
                                if (r_used == CW'(TABLE_ENTRIES)) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_status <= ST_OK;
                                    r_used   <= r_used + CW'(1);
                                    r_alive  <= r_alive + CW'(1);
                                end
                                r_state <= S_DONE;
                            end
                            OP_REMOVE: r_state <= S_REM;
                            OP_SELECT: r_state <= (r_used == '0) ? S_DONE : S_REC;
                            OP_SUCCESS, OP_FAILURE: begin
                                if ({1'b0, i_entry_position} >= r_used) begin
                                    r_status <= ST_BADPOS;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_RMW_RD;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_RMW_RD: r_state <= S_RMW_WR;
                S_RMW_WR: begin
                    r_status <= ST_OK;
                    if (rmw_trip) r_alive <= r_alive - CW'(1);
                    if (rmw_clr)  r_alive <= r_alive + CW'(1);
                    r_state <= S_DONE;
                end
                S_REM: begin
                    // Read r_i while judging entry r_i-1 held in r_rd.
                    if (r_rdv) begin
                        if (r_rd.key == r_key) begin
                            r_rm <= r_rm + CW'(1);
                            if (!r_rd.tripped) r_alive <= r_alive - CW'(1);
                        end else begin
                            r_w <= r_w + CW'(1);
                        end
                    end
                    if (r_i < r_used) begin
                        r_i   <= r_i + CW'(1);
                        r_rdv <= 1'b1;
                    end else begin
                        r_rdv <= 1'b0;
                        if (!r_rdv) begin
                            r_used   <= r_w;
                            r_status <= (r_rm != '0) ? ST_OK : ST_NONE;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_REC: begin
                    if (r_rdv && rec_hit) begin
                        r_alive <= r_alive + CW'(1);
                    end
                    if (r_i < r_used) begin
                        r_i   <= r_i + CW'(1);
                        r_rdv <= 1'b1;
                    end else begin
                        r_rdv <= 1'b0;
                        if (!r_rdv) begin
                            r_state <= (r_alive == '0) ? S_DONE : S_MOD1;
                        end
                    end
                end
                S_MOD1, S_MOD2: begin
                    if (mrsp.done) begin
                        r_spos  <= mrsp.rem;
                        r_state <= S_RDWAIT;
                    end
                end
                S_RDWAIT: r_state <= r_second ? S_PICK2 : S_PICK1;
                S_PICK1: begin
                    if (r_rd.tripped && r_try) begin
                        r_second <= 1'b1;
                        r_state  <= S_MOD2;
                    end else begin
                        r_skey   <= r_rd.key;
                        r_status <= ST_OK;
                        r_state  <= S_DONE;
                    end
                end
                S_PICK2: begin
                    r_skey   <= r_rd.key;
                    r_status <= ST_OK;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid             = r_ovalid;
    assign o_status            = r_status;
    assign o_selected_position = r_spos;
    assign o_selected_key      = r_skey;
    assign o_removed_count     = r_rm;
    assign o_alive_count       = r_alive;
    assign o_entry_count       = r_used;

    // Alive entries never exceed entries in use.
    a_alive_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alive <= r_used) else $error("alive count above entry count");
    // A result is never shown while an item is still at work.
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_state == S_IDLE) else $error("result during work");
    // The write-back step of a report leaves the entry count unchanged.
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state) == S_RMW_WR |-> $stable(r_used)) else $error("report moved count");
endmodule
